[sv/pgcb_pkg.sv]
// ----------------------------------------------------------------------------
// pgcb_pkg
// Shared types and constants of the particle grid cell binning block.
// ----------------------------------------------------------------------------
package pgcb_pkg;

   // defaults of the top level parameters
   localparam int          GRID_MAX_DEF = 16;
   localparam int          JACK_MAX_DEF = 8;
   localparam int unsigned CELL_CAP_DEF = 65535;

   // field widths
   localparam int POS_W      = 32;
   localparam int COORD_W    = POS_W - 1;
   localparam int NAXES      = 3;
   localparam int SCALE_W    = 24;
   localparam int GRID_REG_W = 5;
   localparam int JACK_REG_W = 4;
   localparam int CNT_W      = 16;
   localparam int CELL_OUT_W = 4;
   localparam int LIN_OUT_W  = 12;
   localparam int JACK_OUT_W = 3;

   // Q15.16 times Q8.16 gives Q23.32; the floor keeps the top bits
   localparam int PROD_W    = COORD_W + SCALE_W;
   localparam int FRAC_W    = 32;
   localparam int QUO_W     = PROD_W - FRAC_W;
   localparam int STEP_BITS = 4;
   localparam int STEPS     = (QUO_W + STEP_BITS - 1) / STEP_BITS;
   localparam int DIV_W     = STEPS * STEP_BITS;

   // stream and register port widths
   localparam int REQ_DATA_W = NAXES * POS_W;
   localparam int RSP_PAD_W  = 7;
   localparam int RSP_DATA_W = NAXES * CELL_OUT_W + LIN_OUT_W + CNT_W
                               + NAXES * JACK_OUT_W + RSP_PAD_W;
   localparam int RSP_USER_W = 2;
   localparam int USER_SKIP_BIT = 0;
   localparam int USER_OVF_BIT  = 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SCALE_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SCALE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_JACK_SCALE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_PER_AXIS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_JACK_PER_AXIS = 2'd3;

   // register reset values
   localparam logic [SCALE_W-1:0]    CELL_SCALE_RST    = 24'd65536;
   localparam logic [SCALE_W-1:0]    JACK_SCALE_RST    = 24'd65536;
   localparam logic [GRID_REG_W-1:0] GRID_PER_AXIS_RST = 5'd16;
   localparam logic [JACK_REG_W-1:0] JACK_PER_AXIS_RST = 4'd1;

   typedef struct packed {
      logic [SCALE_W-1:0]    cell_scale;
      logic [SCALE_W-1:0]    jack_scale;
      logic [GRID_REG_W-1:0] grid_per_axis;
      logic [JACK_REG_W-1:0] jack_per_axis;
   } cfg_type;

   // classified request as it waits in the queue
   typedef struct packed {
      logic                           skip;
      logic [NAXES-1:0][COORD_W-1:0]  pos;
   } item_type;

endpackage

[sv/particle_grid_cell_binning.sv]
// ----------------------------------------------------------------------------
// particle_grid_cell_binning
// Bins particles into a 3D cell list and jackknife regions, handing out a
// slot within each cell from a per-cell counter.
//
// Each request carries x, y, z as signed Q16.16. A particle with a negative
// coordinate comes back with skipped set and all other fields zero. Otherwise
// each coordinate is scaled by the Q8.16 cell and jackknife scale registers,
// floored and reduced modulo the axis size, giving the grid cell, its linear
// index and the jackknife region; the cell's count gives the slot and is then
// bumped, or overflow is raised when the cell is full. One particle is in the
// engine at a time; the remainder unit retires 4 quotient bits a cycle, and a
// two-entry queue and the response register let the input and output sides
// stall on their own. After reset a clearing pass zeroes all GRID_MAX^3 cells
// of the count memory (4096 by default), during which no request is taken.
// Registers must be written through the csr port only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module particle_grid_cell_binning #(
   parameter int          GRID_MAX = pgcb_pkg::GRID_MAX_DEF,
   parameter int          JACK_MAX = pgcb_pkg::JACK_MAX_DEF,
   parameter int unsigned CELL_CAP = pgcb_pkg::CELL_CAP_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pgcb_pkg::REQ_DATA_W-1:0]    req_tdata,  // pos_x, pos_y, pos_z
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pgcb_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // cell_x, cell_y, cell_z,
                                                          // cell_linear, slot, jack_x,
                                                          // jack_y, jack_z, zero pad
   output logic [pgcb_pkg::RSP_USER_W-1:0]    rsp_tuser,  // skipped, overflow
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pgcb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pgcb_pkg::CSR_DATA_W-1:0]    csr_data
);

   pgcb_pkg::cfg_type  cfg_ff;
   pgcb_pkg::item_type push_item;
   pgcb_pkg::item_type q_item;
   logic               push, q_full, q_valid, q_pop, clearing;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_scale    <= pgcb_pkg::CELL_SCALE_RST;
         cfg_ff.jack_scale    <= pgcb_pkg::JACK_SCALE_RST;
         cfg_ff.grid_per_axis <= pgcb_pkg::GRID_PER_AXIS_RST;
         cfg_ff.jack_per_axis <= pgcb_pkg::JACK_PER_AXIS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pgcb_pkg::CSR_CELL_SCALE: begin
               cfg_ff.cell_scale <= csr_data;
            end
            pgcb_pkg::CSR_JACK_SCALE: begin
               cfg_ff.jack_scale <= csr_data;
            end
            pgcb_pkg::CSR_GRID_PER_AXIS: begin
               cfg_ff.grid_per_axis <= csr_data[pgcb_pkg::GRID_REG_W-1:0];
            end
            pgcb_pkg::CSR_JACK_PER_AXIS: begin
               cfg_ff.jack_per_axis <= csr_data[pgcb_pkg::JACK_REG_W-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // request side
   pgcb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .clearing   (clearing),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (push),
      .push_item  (push_item)
   );

   // decoupling queue
   pgcb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_item  (q_item)
   );

   // binning engine
   pgcb_back #(
      .GRID_MAX (GRID_MAX),
      .JACK_MAX (JACK_MAX),
      .CELL_CAP (CELL_CAP)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[sv/pgcb_front.sv]
// ----------------------------------------------------------------------------
// pgcb_front
// Request stage: takes a request, flags negative coordinates and hands the
// classified item on to the queue.
// ----------------------------------------------------------------------------
module pgcb_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                clearing,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pgcb_pkg::REQ_DATA_W-1:0]     req_tdata,  // pos_x, pos_y, pos_z
   input  logic                                q_full,
   output logic                                push,
   output pgcb_pkg::item_type                  push_item
);

   logic               valid_ff, valid_in;
   pgcb_pkg::item_type item_ff;
   pgcb_pkg::item_type item_in;

   // classify: any sign bit set means the particle is skipped
   always_comb begin
      item_in.skip = 1'b0;
      item_in.pos  = '0;
      for (int a = 0; a < pgcb_pkg::NAXES; a++) begin
         item_in.skip   = item_in.skip | req_tdata[a * pgcb_pkg::POS_W + pgcb_pkg::COORD_W];
         item_in.pos[a] = req_tdata[a * pgcb_pkg::POS_W +: pgcb_pkg::COORD_W];
      end
   end

   // the stage is free once its item moves into the queue
   assign push       = valid_ff && !q_full;
   assign push_item  = item_ff;
   assign req_tready = !clearing && (!valid_ff || !q_full);

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
   end

endmodule

[sv/pgcb_queue.sv]
// ----------------------------------------------------------------------------
// pgcb_queue
// Two-entry queue between the request stage and the binning engine.
// ----------------------------------------------------------------------------
module pgcb_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pgcb_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output pgcb_pkg::item_type pop_item
);

   pgcb_pkg::item_type entry_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff,  count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign pop_item = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[sv/pgcb_axis.sv]
// ----------------------------------------------------------------------------
// pgcb_axis
// One axis lane: scales a coordinate, floors it and reduces it modulo the
// axis size with a restoring remainder, STEP_BITS (4) bits per step.
// ----------------------------------------------------------------------------
module pgcb_axis #(
   parameter int DW = 5
) (
   input  logic                           clock,
   input  logic                           load,
   input  logic                           step,
   input  logic [pgcb_pkg::COORD_W-1:0]   coord,
   input  logic [pgcb_pkg::SCALE_W-1:0]   scale,
   input  logic [DW-1:0]                  divisor,
   output logic [DW-1:0]                  rem
);

   logic [pgcb_pkg::PROD_W-1:0] prod;
   logic [pgcb_pkg::DIV_W-1:0]  div_ff;
   logic [DW-1:0]               rem_ff;
   logic [DW-1:0]               rem_in;
   logic [DW:0]                 trial;

   // Q23.32 product; only the integer part is kept
   assign prod = pgcb_pkg::PROD_W'(coord) * pgcb_pkg::PROD_W'(scale);

   // remainder steps, most significant dividend bit first
   always_comb begin
      rem_in = rem_ff;
      trial  = '0;
      for (int i = 0; i < pgcb_pkg::STEP_BITS; i++) begin
         trial = {rem_in, div_ff[pgcb_pkg::DIV_W-1-i]};
         if (trial >= {1'b0, divisor}) begin
            rem_in = DW'(trial - {1'b0, divisor});
         end else begin
            rem_in = DW'(trial);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         div_ff <= pgcb_pkg::DIV_W'(prod[pgcb_pkg::PROD_W-1:pgcb_pkg::FRAC_W]);
         rem_ff <= '0;
      end else if (step) begin
         div_ff <= div_ff << pgcb_pkg::STEP_BITS;
         rem_ff <= rem_in;
      end
   end

   assign rem = rem_ff;

endmodule

[sv/pgcb_back.sv]
// ----------------------------------------------------------------------------
// pgcb_back
// Binning engine: clears the count memory after reset, runs the six axis
// lanes, forms the linear cell index, reads and bumps the per-cell count
// and drives the response register.
module pgcb_back #(
   parameter int          GRID_MAX = pgcb_pkg::GRID_MAX_DEF,
   parameter int          JACK_MAX = pgcb_pkg::JACK_MAX_DEF,
   parameter int unsigned CELL_CAP = pgcb_pkg::CELL_CAP_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pgcb_pkg::cfg_type                  cfg,
   input  logic                               q_valid,
   input  pgcb_pkg::item_type                 q_item,
   output logic                               q_pop,
   output logic                               clearing,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pgcb_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // cell_x, cell_y, cell_z,
                                                          // cell_linear, slot, jack_x,
                                                          // jack_y, jack_z, zero pad
   output logic [pgcb_pkg::RSP_USER_W-1:0]    rsp_tuser   // skipped, overflow
);

   localparam int GW     = $clog2(GRID_MAX + 1);
   localparam int JW     = $clog2(JACK_MAX + 1);
   localparam int NCELLS = GRID_MAX * GRID_MAX * GRID_MAX;
   localparam int LIN_W  = (NCELLS > 1) ? $clog2(NCELLS) : 1;
   localparam int LINX_W = (LIN_W > pgcb_pkg::LIN_OUT_W) ? LIN_W : pgcb_pkg::LIN_OUT_W;
   localparam int SC_W   = (pgcb_pkg::STEPS > 1) ? $clog2(pgcb_pkg::STEPS) : 1;
   localparam logic [pgcb_pkg::CNT_W-1:0] CAP =
      (CELL_CAP < (2 ** pgcb_pkg::CNT_W - 1)) ? pgcb_pkg::CNT_W'(CELL_CAP) : '1;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_DIV   = 7'b0000100,
      S_LIN1  = 7'b0001000,
      S_LIN2  = 7'b0010000,
      S_READ  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type                  state_ff, state_in;
   logic [LIN_W-1:0]           clr_cnt_ff, clr_cnt_in;
   logic [SC_W-1:0]            step_cnt_ff, step_cnt_in;
   logic                       skip_ff, skip_in;
   logic [LINX_W-1:0]          part_ff, part_in;
   logic [LINX_W-1:0]          lin_ff, lin_in;
   logic [pgcb_pkg::CNT_W-1:0] rd_cnt_ff;
   logic [pgcb_pkg::CNT_W-1:0] cnt_mem [NCELLS];
   logic                       rsp_valid_ff;
   logic [pgcb_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [pgcb_pkg::RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic                       lane_load, lane_step, rd_en, rsp_load;
   logic                       mem_we;
   logic [LIN_W-1:0]           mem_wa;
   logic [pgcb_pkg::CNT_W-1:0] mem_wd;
   logic                       out_free, cnt_full;
   logic [GW-1:0]              g_eff;
   logic [JW-1:0]              jn_eff;
   logic [GW-1:0]              cell_rem [pgcb_pkg::NAXES];
   logic [JW-1:0]              jack_rem [pgcb_pkg::NAXES];

   // axis sizes: zero acts as one, oversize as the maximum
   always_comb begin
      if (cfg.grid_per_axis == '0) begin
         g_eff = GW'(1);
      end else if (32'(cfg.grid_per_axis) > GRID_MAX) begin
         g_eff = GW'(GRID_MAX);
      end else begin
         g_eff = GW'(cfg.grid_per_axis);
      end
      if (cfg.jack_per_axis == '0) begin
         jn_eff = JW'(1);
      end else if (32'(cfg.jack_per_axis) > JACK_MAX) begin
         jn_eff = JW'(JACK_MAX);
      end else begin
         jn_eff = JW'(cfg.jack_per_axis);
      end
   end

   // grid and jackknife lanes per axis
   for (genvar a = 0; a < pgcb_pkg::NAXES; a++) begin : g_lane
      pgcb_axis #(.DW(GW)) u_cell (
         .clock   (clock),
         .load    (lane_load),
         .step    (lane_step),
         .coord   (q_item.pos[a]),
         .scale   (cfg.cell_scale),
         .divisor (g_eff),
         .rem     (cell_rem[a])
      );
      pgcb_axis #(.DW(JW)) u_jack (
         .clock   (clock),
         .load    (lane_load),
         .step    (lane_step),
         .coord   (q_item.pos[a]),
         .scale   (cfg.jack_scale),
         .divisor (jn_eff),
         .rem     (jack_rem[a])
      );
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign cnt_full = (rd_cnt_ff >= CAP);
   assign clearing = (state_ff == S_CLEAR);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      step_cnt_in = step_cnt_ff;
      skip_in     = skip_ff;
      part_in     = part_ff;
      lin_in      = lin_ff;
      q_pop       = 1'b0;
      lane_load   = 1'b0;
      lane_step   = 1'b0;
      rd_en       = 1'b0;
      rsp_load    = 1'b0;
      mem_we      = 1'b0;
      mem_wa      = lin_ff[LIN_W-1:0];
      mem_wd      = rd_cnt_ff + pgcb_pkg::CNT_W'(1);
      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_cnt_ff;
            mem_wd = '0;
            if (clr_cnt_ff == LIN_W'(NCELLS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + LIN_W'(1);
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               skip_in = q_item.skip;
               if (q_item.skip) begin
                  state_in = S_DONE;
               end else begin
                  lane_load   = 1'b1;
                  step_cnt_in = '0;
                  state_in    = S_DIV;
               end
            end
         end
         S_DIV: begin
            lane_step = 1'b1;
            if (step_cnt_ff == SC_W'(pgcb_pkg::STEPS - 1)) begin
               state_in = S_LIN1;
            end else begin
               step_cnt_in = step_cnt_ff + SC_W'(1);
            end
         end
         S_LIN1: begin
            part_in  = LINX_W'(cell_rem[0]) * LINX_W'(g_eff) + LINX_W'(cell_rem[1]);
            state_in = S_LIN2;
         end
         S_LIN2: begin
            lin_in   = part_ff * LINX_W'(g_eff) + LINX_W'(cell_rem[2]);
            state_in = S_READ;
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               mem_we   = !skip_ff && !cnt_full;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response fields
   always_comb begin
      rsp_user_in = '0;
      rsp_data_in = '0;
      if (skip_ff) begin
         rsp_user_in[pgcb_pkg::USER_SKIP_BIT] = 1'b1;
      end else begin
         rsp_user_in[pgcb_pkg::USER_OVF_BIT] = cnt_full;
         rsp_data_in = {
            pgcb_pkg::RSP_PAD_W'(0),
            pgcb_pkg::JACK_OUT_W'(jack_rem[2]),
            pgcb_pkg::JACK_OUT_W'(jack_rem[1]),
            pgcb_pkg::JACK_OUT_W'(jack_rem[0]),
            cnt_full ? pgcb_pkg::CNT_W'(0) : rd_cnt_ff,
            lin_ff[pgcb_pkg::LIN_OUT_W-1:0],
            pgcb_pkg::CELL_OUT_W'(cell_rem[2]),
            pgcb_pkg::CELL_OUT_W'(cell_rem[1]),
            pgcb_pkg::CELL_OUT_W'(cell_rem[0])
         };
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         step_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_cnt_ff  <= clr_cnt_in;
         step_cnt_ff <= step_cnt_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      skip_ff <= skip_in;
      part_ff <= part_in;
      lin_ff  <= lin_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   // per-cell count memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cnt_mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_cnt_ff <= cnt_mem[lin_ff[LIN_W-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
